// File: hw/rtl/pbio_pkg.sv
`default_nettype none

package pbio_pkg;

   localparam int SWITCH_ROWS_DEFAULT = 16;

   // reachable rows are limited by the 4-bit row number of a load
   localparam int LOAD_ROW_W   = 4;
   localparam int READ_INDEX_W = 9;
   localparam int FIXED_ROW    = 9;

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_TICK  = 2'd2,
      REQ_LOAD  = 2'd3
   } req_kind_type;

   localparam logic [15:0] ADDR_COIN_SOL   = 16'h9000;
   localparam logic [15:0] ADDR_SWITCH_SEL = 16'h9003;
   localparam logic [15:0] ADDR_TARGET_SOL = 16'h9006;
   localparam logic [15:0] ADDR_RESET_SOL  = 16'h9007;
   localparam logic [15:0] ADDR_COLUMN     = 16'ha008;
   localparam logic [15:0] ADDR_LAMP_BASE  = 16'ha010;
   localparam logic [15:0] ADDR_SEGMENT    = 16'ha018;
   localparam logic [15:0] ADDR_SOUND      = 16'hf000;
   localparam logic [15:0] ADDR_SWITCH_RD  = 16'ha020;
   localparam logic [15:0] ADDR_ROW9_RD    = 16'ha038;
   localparam logic [15:0] ADDR_PHASE_RD   = 16'he000;

   localparam int SOL_COIN   = 18;
   localparam int SOL_TARGET = 16;
   localparam int SOL_RESET  = 17;

   localparam logic [5:0] COUNT_MAX = 6'd48;

   localparam logic [2:0] COL_PERM [7] = '{3'd5, 3'd4, 3'd3, 3'd0, 3'd6, 3'd1, 3'd2};

   typedef struct packed {
      req_kind_type kind;
      logic [15:0]  address;
      logic [7:0]   data;
      logic [3:0]   row;
   } item_type;

   typedef struct packed {
      logic [7:0]  read_value;
      logic [19:0] solenoid_word;
      logic        lamp_strobe;
      logic [3:0]  lamp_row;
      logic [7:0]  lamp_byte;
      logic        digit_strobe;
      logic [5:0]  digit_index;
      logic [7:0]  digit_segments;
      logic        sound_strobe;
      logic [7:0]  sound_code;
      logic        timer_trigger;
      logic        phase_flag;
   } result_type;

   function automatic logic [7:0] reorder_segments(input logic [7:0] d);
      return {d[0], d[6], d[2], d[1], d[4], d[5], d[7], d[3]};
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pinball_board_io_decoder_top.sv
`default_nettype none

// Main-CPU I/O decoder of a pinball controller. Each request word is a bus
// write, bus read, mains zero-cross tick or switch row load, and yields exactly
// one response word carrying read data, the 20-bit solenoid state, lamp, digit
// and sound strobes with their data, the timer trigger level and the phase flag.
// A request passes an input register and a result register, so the block takes
// one word per cycle unless rsp_stall holds back the result register. The
// solenoid, column, counter and phase state is updated in the single decode
// step between the two registers. Switch rows clear on reset with no extra pass.
module pinball_board_io_decoder_top #(
   parameter int SWITCH_ROWS = pbio_pkg::SWITCH_ROWS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [15:0] req_bus_address,
   input  wire logic [7:0]  req_bus_data,
   input  wire logic [3:0]  req_row_number,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_read_value,
   output logic [19:0]      rsp_solenoid_word,
   output logic             rsp_lamp_strobe,
   output logic [3:0]       rsp_lamp_row,
   output logic [7:0]       rsp_lamp_byte,
   output logic             rsp_digit_strobe,
   output logic [5:0]       rsp_digit_index,
   output logic [7:0]       rsp_digit_segments,
   output logic             rsp_sound_strobe,
   output logic [7:0]       rsp_sound_code,
   output logic             rsp_timer_trigger,
   output logic             rsp_phase_flag
);
   import pbio_pkg::*;

   logic       in_valid_ff,  in_valid_in;
   item_type   in_item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type result;

   logic advance;
   logic take;
   logic item_go;

   // result stage frees when empty or when its word leaves this cycle
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign item_go   = in_valid_ff && advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_item_ff <= '0;
      end else if (take) begin
         in_item_ff.kind    <= req_kind_type'(req_type);
         in_item_ff.address <= req_bus_address;
         in_item_ff.data    <= req_bus_data;
         in_item_ff.row     <= req_row_number;
      end
      if (item_go) begin
         rsp_ff <= result;
      end
   end

   pbio_core #(
      .SWITCH_ROWS(SWITCH_ROWS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .item_go(item_go),
      .item   (in_item_ff),
      .result (result)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_value     = rsp_ff.read_value;
   assign rsp_solenoid_word  = rsp_ff.solenoid_word;
   assign rsp_lamp_strobe    = rsp_ff.lamp_strobe;
   assign rsp_lamp_row       = rsp_ff.lamp_row;
   assign rsp_lamp_byte      = rsp_ff.lamp_byte;
   assign rsp_digit_strobe   = rsp_ff.digit_strobe;
   assign rsp_digit_index    = rsp_ff.digit_index;
   assign rsp_digit_segments = rsp_ff.digit_segments;
   assign rsp_sound_strobe   = rsp_ff.sound_strobe;
   assign rsp_sound_code     = rsp_ff.sound_code;
   assign rsp_timer_trigger  = rsp_ff.timer_trigger;
   assign rsp_phase_flag     = rsp_ff.phase_flag;

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled with a free pipeline stage");

   a_decode_reaches_output: assert property (@(posedge clock) disable iff (reset)
      item_go |=> rsp_valid)
      else $error("decoded word lost before the result register");

   a_digit_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_digit_strobe) |-> (rsp_digit_index <= 6'd41))
      else $error("digit index beyond display");

endmodule

`default_nettype wire

// File: hw/rtl/pbio_switch_store.sv
`default_nettype none

module pbio_switch_store #(
   parameter int SWITCH_ROWS = pbio_pkg::SWITCH_ROWS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              wr_en,
   input  wire logic [pbio_pkg::LOAD_ROW_W-1:0]   wr_row,
   input  wire logic [7:0]                        wr_data,
   input  wire logic [pbio_pkg::READ_INDEX_W-1:0] rd_index,
   output logic      [7:0]                        rd_byte,
   output logic      [7:0]                        fixed_byte
);
   import pbio_pkg::*;

   // rows past what a load can reach stay zero, so they need no storage
   localparam int LOAD_SPAN   = 1 << LOAD_ROW_W;
   localparam int STORE_DEPTH = (SWITCH_ROWS < LOAD_SPAN) ? SWITCH_ROWS : LOAD_SPAN;
   localparam int IDX_W       = $clog2(STORE_DEPTH);

   logic [7:0] rows_ff [STORE_DEPTH];

   logic [LOAD_ROW_W:0]   wr_row_ext;
   logic [READ_INDEX_W-1:0] fixed_index;

   assign wr_row_ext  = {1'b0, wr_row};
   assign fixed_index = READ_INDEX_W'(FIXED_ROW);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            rows_ff[i] <= '0;
         end
      end else if (wr_en && (wr_row_ext < (LOAD_ROW_W + 1)'(STORE_DEPTH))) begin
         rows_ff[wr_row[IDX_W-1:0]] <= wr_data;
      end
   end

   always_comb begin
      if (rd_index < READ_INDEX_W'(STORE_DEPTH)) begin
         rd_byte = ~rows_ff[rd_index[IDX_W-1:0]];
      end else begin
         rd_byte = 8'hff;
      end
      if (fixed_index < READ_INDEX_W'(STORE_DEPTH)) begin
         fixed_byte = ~rows_ff[fixed_index[IDX_W-1:0]];
      end else begin
         fixed_byte = 8'hff;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/pbio_core.sv
`default_nettype none

module pbio_core #(
   parameter int SWITCH_ROWS = pbio_pkg::SWITCH_ROWS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 item_go,
   input  wire pbio_pkg::item_type   item,
   output pbio_pkg::result_type      result
);
   import pbio_pkg::*;

   logic [19:0] sol_ff,    sol_in;
   logic [7:0]  sel_ff,    sel_in;
   logic [2:0]  col_ff,    col_in;
   logic [5:0]  count_ff,  count_in;
   logic        phase_ff,  phase_in;
   logic        toggle_ff, toggle_in;

   logic                    load_en;
   logic [READ_INDEX_W-1:0] rd_index;
   logic [7:0]              rd_byte;
   logic [7:0]              fixed_byte;
   logic                    emit;
   logic [5:0]              base;
   logic [2:0]              off;

   assign rd_index = READ_INDEX_W'(sel_ff) + READ_INDEX_W'(1);
   assign load_en  = item_go && (item.kind == REQ_LOAD);
   assign off      = item.address[2:0];

   pbio_switch_store #(
      .SWITCH_ROWS(SWITCH_ROWS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (load_en),
      .wr_row    (item.row),
      .wr_data   (item.data),
      .rd_index  (rd_index),
      .rd_byte   (rd_byte),
      .fixed_byte(fixed_byte)
   );

   // display digit base for each strobing count of the segment word stream
   always_comb begin
      emit = 1'b1;
      unique case (count_ff)
         6'd7:    base = 6'd20;
         6'd15:   base = 6'd27;
         6'd23:   base = 6'd6;
         6'd31:   base = 6'd13;
         6'd39:   base = 6'd34;
         6'd47:   base = 6'd41;
         default: begin
            base = 6'd0;
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      sol_in    = sol_ff;
      sel_in    = sel_ff;
      col_in    = col_ff;
      count_in  = count_ff;
      phase_in  = phase_ff;
      toggle_in = toggle_ff;
      result    = '0;

      unique case (item.kind)
         REQ_WRITE: begin
            priority if (item.address == ADDR_COIN_SOL) begin
               sol_in[SOL_COIN] = item.data[0];
            end else if (item.address == ADDR_SWITCH_SEL) begin
               sel_in = item.data;
            end else if (item.address == ADDR_TARGET_SOL) begin
               sol_in[SOL_TARGET] = item.data[0];
            end else if (item.address == ADDR_RESET_SOL) begin
               sol_in[SOL_RESET] = item.data[0];
            end else if (item.address == ADDR_COLUMN) begin
               // lowest set bit wins; an empty pattern keeps the column
               for (int b = 6; b >= 0; b--) begin
                  if (item.data[b]) begin
                     col_in = COL_PERM[b];
                  end
               end
               count_in = '0;
            end else if (item.address[15:3] == ADDR_LAMP_BASE[15:3]) begin
               result.lamp_strobe = 1'b1;
               result.lamp_row    = {~phase_ff, off};
               result.lamp_byte   = item.data;
               if (!off[2] || (off == 3'd7)) begin
                  sol_in[off] = item.data[3];
               end
               sol_in[{2'b01, off}] = item.data[5];
            end else if (item.address == ADDR_SEGMENT) begin
               if (emit && ({3'b000, col_ff} <= base)) begin
                  result.digit_strobe   = 1'b1;
                  result.digit_index    = base - {3'b000, col_ff};
                  result.digit_segments = reorder_segments(~item.data);
               end
               if (count_ff < COUNT_MAX) begin
                  count_in = count_ff + 6'd1;
               end
            end else if (item.address == ADDR_SOUND) begin
               result.sound_strobe = 1'b1;
               result.sound_code   = item.data;
            end else begin
               // unmapped write, ignored
            end
         end
         REQ_READ: begin
            priority if (item.address == ADDR_SWITCH_RD) begin
               result.read_value = rd_byte;
            end else if (item.address == ADDR_ROW9_RD) begin
               result.read_value = fixed_byte;
            end else if (item.address == ADDR_PHASE_RD) begin
               result.read_value = {7'b0, phase_ff};
            end else begin
               // unmapped read returns zero
            end
         end
         REQ_TICK: begin
            result.timer_trigger = toggle_ff;
            phase_in  = phase_ff ^ toggle_ff;
            toggle_in = ~toggle_ff;
         end
         REQ_LOAD: begin
         end
      endcase

      result.solenoid_word = sol_in;
      result.phase_flag    = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sol_ff    <= '0;
         sel_ff    <= '0;
         col_ff    <= '0;
         count_ff  <= '0;
         phase_ff  <= 1'b0;
         toggle_ff <= 1'b0;
      end else if (item_go) begin
         sol_ff    <= sol_in;
         sel_ff    <= sel_in;
         col_ff    <= col_in;
         count_ff  <= count_in;
         phase_ff  <= phase_in;
         toggle_ff <= toggle_in;
      end
   end

   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("segment write counter past saturation");

   a_column_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= 3'd6)
      else $error("digit column outside permutation range");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      item_go |-> $onehot0({result.lamp_strobe, result.digit_strobe, result.sound_strobe}))
      else $error("more than one output strobe for one word");

   a_phase_on_second_tick: assert property (@(posedge clock) disable iff (reset)
      (item_go && (item.kind == REQ_TICK) && !toggle_ff) |=> $stable(phase_ff))
      else $error("phase flipped on first tick of a pair");

endmodule

`default_nettype wire

// File: tb/pinball_board_io_decoder_top_tb.sv
`timescale 1ns / 100ps

module pinball_board_io_decoder_top_tb;
   import pbio_pkg::*;

   localparam int SWITCH_ROWS    = SWITCH_ROWS_DEFAULT;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LINES   = 40;

   // lowest set column bit -> digit column
   localparam logic [2:0] DIGIT_OF_BIT [7] = '{3'd5, 3'd4, 3'd3, 3'd0, 3'd6, 3'd1, 3'd2};

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = REQ_WRITE;
   logic [15:0] req_bus_address = '0;
   logic [7:0]  req_bus_data = '0;
   logic [3:0]  req_row_number = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_read_value;
   logic [19:0] rsp_solenoid_word;
   logic        rsp_lamp_strobe;
   logic [3:0]  rsp_lamp_row;
   logic [7:0]  rsp_lamp_byte;
   logic        rsp_digit_strobe;
   logic [5:0]  rsp_digit_index;
   logic [7:0]  rsp_digit_segments;
   logic        rsp_sound_strobe;
   logic [7:0]  rsp_sound_code;
   logic        rsp_timer_trigger;
   logic        rsp_phase_flag;

   pinball_board_io_decoder_top #(
      .SWITCH_ROWS(SWITCH_ROWS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_bus_address    (req_bus_address),
      .req_bus_data       (req_bus_data),
      .req_row_number     (req_row_number),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_value     (rsp_read_value),
      .rsp_solenoid_word  (rsp_solenoid_word),
      .rsp_lamp_strobe    (rsp_lamp_strobe),
      .rsp_lamp_row       (rsp_lamp_row),
      .rsp_lamp_byte      (rsp_lamp_byte),
      .rsp_digit_strobe   (rsp_digit_strobe),
      .rsp_digit_index    (rsp_digit_index),
      .rsp_digit_segments (rsp_digit_segments),
      .rsp_sound_strobe   (rsp_sound_strobe),
      .rsp_sound_code     (rsp_sound_code),
      .rsp_timer_trigger  (rsp_timer_trigger),
      .rsp_phase_flag     (rsp_phase_flag)
   );

   // decoder state as the board sees it
   logic [19:0] sol_state = '0;
   logic [7:0]  sw_select = '0;
   logic [2:0]  col_sel = '0;
   logic [5:0]  seg_count = '0;
   logic        mains_phase = 1'b0;
   logic        tick_level = 1'b0;
   logic [7:0]  sw_rows [SWITCH_ROWS] = '{default: 8'h00};

   result_type    expected_results [$];
   idle_mode_type idle_mode = IDLE_NONE;
   idle_mode_type modes [4] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};

   int mismatch_count = 0;
   int words_sent = 0;
   int words_checked = 0;
   int lamp_count = 0;
   int digit_count = 0;
   int sound_count = 0;
   int switch_reads = 0;
   int tick_count = 0;
   int quiet_cycles = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic decode_item(input item_type it, output result_type res);
      logic [8:0] sw_index;
      logic [2:0] lamp_off;
      logic [5:0] seg_base;
      logic       seg_emit;
      logic [7:0] inv;
      res = '0;
      case (it.kind)
         REQ_WRITE: begin
            if (it.address == ADDR_COIN_SOL) begin
               sol_state[SOL_COIN] = it.data[0];
            end else if (it.address == ADDR_SWITCH_SEL) begin
               sw_select = it.data;
            end else if (it.address == ADDR_TARGET_SOL) begin
               sol_state[SOL_TARGET] = it.data[0];
            end else if (it.address == ADDR_RESET_SOL) begin
               sol_state[SOL_RESET] = it.data[0];
            end else if (it.address == ADDR_COLUMN) begin
               // scan downwards so the lowest set bit wins; no bit keeps the column
               for (int b = 6; b >= 0; b--) begin
                  if (it.data[b]) col_sel = DIGIT_OF_BIT[b];
               end
               seg_count = '0;
            end else if (it.address >= ADDR_LAMP_BASE && it.address <= ADDR_LAMP_BASE + 16'd7) begin
               lamp_off = it.address[2:0];
               res.lamp_strobe = 1'b1;
               res.lamp_row = {~mains_phase, lamp_off};
               res.lamp_byte = it.data;
               if (lamp_off <= 3'd3 || lamp_off == 3'd7) sol_state[lamp_off] = it.data[3];
               sol_state[int'(lamp_off) + 8] = it.data[5];
               lamp_count++;
            end else if (it.address == ADDR_SEGMENT) begin
               seg_emit = 1'b1;
               seg_base = '0;
               case (seg_count)
                  6'd7:    seg_base = 6'd20;
                  6'd15:   seg_base = 6'd27;
                  6'd23:   seg_base = 6'd6;
                  6'd31:   seg_base = 6'd13;
                  6'd39:   seg_base = 6'd34;
                  6'd47:   seg_base = 6'd41;
                  default: seg_emit = 1'b0;
               endcase
               if (seg_emit && col_sel <= seg_base) begin
                  inv = ~it.data;
                  res.digit_strobe = 1'b1;
                  res.digit_index = seg_base - 6'(col_sel);
                  res.digit_segments[7]   = inv[0];
                  res.digit_segments[5:4] = inv[2:1];
                  res.digit_segments[0]   = inv[3];
                  res.digit_segments[3]   = inv[4];
                  res.digit_segments[2]   = inv[5];
                  res.digit_segments[6]   = inv[6];
                  res.digit_segments[1]   = inv[7];
                  digit_count++;
               end
               if (seg_count < COUNT_MAX) seg_count++;
            end else if (it.address == ADDR_SOUND) begin
               res.sound_strobe = 1'b1;
               res.sound_code = it.data;
               sound_count++;
            end
         end
         REQ_READ: begin
            if (it.address == ADDR_SWITCH_RD) begin
               sw_index = 9'd1 + 9'(sw_select);
               if (sw_index >= SWITCH_ROWS) res.read_value = 8'hff;
               else res.read_value = ~sw_rows[sw_index];
               switch_reads++;
            end else if (it.address == ADDR_ROW9_RD) begin
               res.read_value = ~sw_rows[FIXED_ROW];
               switch_reads++;
            end else if (it.address == ADDR_PHASE_RD) begin
               res.read_value = {7'd0, mains_phase};
            end
         end
         REQ_TICK: begin
            res.timer_trigger = tick_level;
            if (tick_level) mains_phase = ~mains_phase;
            tick_level = ~tick_level;
            tick_count++;
         end
         default: begin
            if (it.row < SWITCH_ROWS) sw_rows[it.row] = it.data;
         end
      endcase
      res.solenoid_word = sol_state;
      res.phase_flag = mains_phase;
   endtask

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LINES) $display("ERROR @%0t: %s", $time, msg);
   endtask

   task automatic compare_field(input string name, input logic [19:0] got,
                                input logic [19:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h (word %0d)",
                                   name, got, want, words_checked));
   endtask

   // one word onto the request channel, with random gaps in front of it
   task automatic send_item(input req_kind_type kind, input logic [15:0] addr,
                            input logic [7:0] data, input logic [3:0] row);
      int         gap_pct;
      item_type   it;
      result_type res;
      gap_pct = (idle_mode == IDLE_SENDER) ? 57 : (idle_mode == IDLE_BOTH) ? 11 : 0;
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_bus_address <= addr;
      req_bus_data <= data;
      req_row_number <= row;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      it.kind = kind;
      it.address = addr;
      it.data = data;
      it.row = row;
      decode_item(it, res);
      expected_results.push_back(res);
      words_sent++;
   endtask

   task automatic bus_write(input logic [15:0] addr, input logic [7:0] data);
      send_item(REQ_WRITE, addr, data, 4'($urandom));
   endtask

   task automatic bus_read(input logic [15:0] addr);
      send_item(REQ_READ, addr, 8'($urandom), 4'($urandom));
   endtask

   task automatic mains_tick();
      send_item(REQ_TICK, 16'($urandom), 8'($urandom), 4'($urandom));
   endtask

   task automatic load_row(input logic [3:0] row, input logic [7:0] data);
      send_item(REQ_LOAD, 16'($urandom), data, row);
   endtask

   task automatic random_access();
      int          pick;
      logic [15:0] addr;
      logic [7:0]  data;
      pick = $urandom_range(0, 99);
      data = 8'($urandom);
      if (pick < 45) begin
         case ($urandom_range(0, 8))
            0: addr = ADDR_COIN_SOL;
            1: begin
               addr = ADDR_SWITCH_SEL;
               // mostly rows inside the store, now and then past it
               if ($urandom_range(0, 3) != 0) data = 8'($urandom_range(0, 16));
            end
            2: addr = ADDR_TARGET_SOL;
            3: addr = ADDR_RESET_SOL;
            4: addr = ADDR_COLUMN;
            5: addr = ADDR_LAMP_BASE + 16'($urandom_range(0, 7));
            6: addr = ADDR_SEGMENT;
            7: addr = ADDR_SOUND;
            default: addr = 16'($urandom);
         endcase
         bus_write(addr, data);
      end else if (pick < 70) begin
         case ($urandom_range(0, 4))
            0, 1: addr = ADDR_SWITCH_RD;
            2: addr = ADDR_ROW9_RD;
            3: addr = ADDR_PHASE_RD;
            default: addr = 16'($urandom);
         endcase
         bus_read(addr);
      end else if (pick < 82) begin
         mains_tick();
      end else begin
         load_row(4'($urandom), data);
      end
   endtask

   // column select followed by a run of segment writes, with odd stray words
   task automatic digit_frame(input int seg_writes);
      int         b;
      logic [7:0] pattern;
      b = $urandom_range(0, 6);
      pattern = (8'($urandom) | (8'd1 << b)) & (8'hff << b);
      if ($urandom_range(0, 4) == 0) pattern = 8'($urandom);
      bus_write(ADDR_COLUMN, pattern);
      repeat (seg_writes) begin
         if ($urandom_range(0, 99) < 8) random_access();
         bus_write(ADDR_SEGMENT, 8'($urandom));
      end
   endtask

   task automatic test_switch_rows();
      load_row(4'd1, 8'ha5);
      load_row(4'd9, 8'h3c);
      load_row(4'd15, 8'hff);
      bus_read(ADDR_SWITCH_RD);
      bus_read(ADDR_ROW9_RD);
      bus_write(ADDR_SWITCH_SEL, 8'h0e);
      bus_read(ADDR_SWITCH_RD);
      bus_write(ADDR_SWITCH_SEL, 8'hff);
      bus_read(ADDR_SWITCH_RD);
      bus_read(16'h0000);
   endtask

   task automatic test_solenoid_bits();
      bus_write(ADDR_COIN_SOL, 8'hff);
      bus_write(ADDR_TARGET_SOL, 8'h01);
      bus_write(ADDR_RESET_SOL, 8'h01);
      bus_write(ADDR_LAMP_BASE, 8'hff);
      bus_write(ADDR_LAMP_BASE + 16'd7, 8'hff);
      bus_write(ADDR_LAMP_BASE + 16'd4, 8'h28);
      bus_write(ADDR_COIN_SOL, 8'hfe);
      bus_write(16'hffff, 8'hff);
   endtask

   task automatic test_column_select();
      bus_write(ADDR_COLUMN, 8'h00);
      bus_write(ADDR_COLUMN, 8'h80);
      bus_write(ADDR_COLUMN, 8'h40);
   endtask

   task automatic test_phase_and_sound();
      mains_tick();
      mains_tick();
      bus_read(ADDR_PHASE_RD);
      bus_write(ADDR_LAMP_BASE + 16'd2, 8'h08);
      mains_tick();
      mains_tick();
      bus_write(ADDR_SOUND, 8'hff);
      bus_write(ADDR_SOUND, 8'h00);
   endtask

   task automatic test_digit_frames();
      foreach (modes[m]) begin
         idle_mode = modes[m];
         digit_frame($urandom_range(48, 52));
      end
   endtask

   task automatic test_random_traffic();
      int target;
      foreach (modes[m]) begin
         idle_mode = modes[m];
         target = words_sent + 150;
         while (words_sent < target) begin
            if ($urandom_range(0, 99) < 4) begin
               if ($urandom_range(0, 3) == 0) digit_frame($urandom_range(1, 40));
               else digit_frame($urandom_range(44, 52));
            end else begin
               random_access();
            end
         end
      end
   endtask

   always @(posedge clock) begin
      case (idle_mode)
         IDLE_RECEIVER: rsp_stall <= ($urandom_range(0, 99) < 57);
         IDLE_BOTH:     rsp_stall <= ($urandom_range(0, 99) < 11);
         default:       rsp_stall <= 1'b0;
      endcase
   end

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_results.size() == 0) begin
            report_mismatch("response word with nothing outstanding");
         end else begin
            want = expected_results.pop_front();
            compare_field("read_value", rsp_read_value, want.read_value);
            compare_field("solenoid_word", rsp_solenoid_word, want.solenoid_word);
            compare_field("lamp_strobe", rsp_lamp_strobe, want.lamp_strobe);
            compare_field("lamp_row", rsp_lamp_row, want.lamp_row);
            compare_field("lamp_byte", rsp_lamp_byte, want.lamp_byte);
            compare_field("digit_strobe", rsp_digit_strobe, want.digit_strobe);
            compare_field("digit_index", rsp_digit_index, want.digit_index);
            compare_field("digit_segments", rsp_digit_segments, want.digit_segments);
            compare_field("sound_strobe", rsp_sound_strobe, want.sound_strobe);
            compare_field("sound_code", rsp_sound_code, want.sound_code);
            compare_field("timer_trigger", rsp_timer_trigger, want.timer_trigger);
            compare_field("phase_flag", rsp_phase_flag, want.phase_flag);
            words_checked++;
         end
      end
   end

   // nothing moving on either channel for too long means a hang
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d words still outstanding", expected_results.size());
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      idle_mode = IDLE_NONE;
      test_switch_rows();
      test_solenoid_bits();
      test_column_select();
      test_phase_and_sound();
      test_digit_frames();
      test_random_traffic();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (expected_results.size() != 0) report_mismatch("words left without a response");
      $display("Sent %0d words, checked %0d responses; %0d ticks, %0d switch reads.",
               words_sent, words_checked, tick_count, switch_reads);
      $display("Saw %0d lamp rows, %0d display digits, %0d sound commands, %0d mismatches.",
               lamp_count, digit_count, sound_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
